>>> hdl/dsdn_pkg.sv
// ----------------------------------------------------------------------------
// dsdn_pkg
// Types, widths and the month offset table shared by the date-to-day-count
// core and its stages.
// ----------------------------------------------------------------------------
package dsdn_pkg;

	localparam int unsigned CharW   = 8;
	localparam int unsigned DigitW  = 9;   // signed byte - 48
	localparam int unsigned YearW   = 20;  // signed weighted year sum
	localparam int unsigned FieldW  = 14;  // signed weighted month/day sum
	localparam int unsigned PrevW   = 14;  // year - 1, 1899..9998
	localparam int unsigned MonthW  = 4;
	localparam int unsigned DayW    = 5;
	localparam int unsigned CentW   = 7;   // (year - 1) / 100, 18..99
	localparam int unsigned RecipW  = 13;
	localparam int unsigned RecipSh = 19;
	localparam int unsigned ProdW   = PrevW + RecipW;
	localparam int unsigned CountW  = 22;
	localparam int unsigned OffsW   = 9;

	// 2^19 / 100 rounded up; exact floor for every value below 10000
	localparam logic [RecipW-1:0] Recip100 = 13'd5243;

	localparam logic [CentW-1:0]  CentLast = 7'd99;
	localparam logic [MonthW-1:0] MonthFeb = 4'd2;

	typedef struct packed {
		logic [CharW-1:0] year_char_thousands;
		logic [CharW-1:0] year_char_hundreds;
		logic [CharW-1:0] year_char_tens;
		logic [CharW-1:0] year_char_units;
		logic [CharW-1:0] month_char_tens;
		logic [CharW-1:0] month_char_units;
		logic [CharW-1:0] day_char_tens;
		logic [CharW-1:0] day_char_units;
	} request_t;

	typedef struct packed {
		logic [CountW-1:0] day_number;
		logic              date_valid;
	} result_t;

	// range-checked date handed from the parse stage to the count stages
	typedef struct packed {
		logic              ok;
		logic [PrevW-1:0]  prev;
		logic [MonthW-1:0] month;
		logic [DayW-1:0]   day;
	} date_t;

	// days before the month; index is month - 1
	function automatic logic [OffsW-1:0] days_before(input logic [MonthW-1:0] idx);
		logic [OffsW-1:0] r;
		case (idx)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd59;
			4'd3:    r = 9'd90;
			4'd4:    r = 9'd120;
			4'd5:    r = 9'd151;
			4'd6:    r = 9'd181;
			4'd7:    r = 9'd212;
			4'd8:    r = 9'd243;
			4'd9:    r = 9'd273;
			4'd10:   r = 9'd304;
			4'd11:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

>>> hdl/dsdn_parse.sv
// ----------------------------------------------------------------------------
// dsdn_parse
// Turns the eight registered bytes into year, month and day, checks their
// ranges and registers the result.
// ----------------------------------------------------------------------------
module dsdn_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vld_s1,
	input  dsdn_pkg::request_t  req_s1,
	output logic                vld_s2,
	output dsdn_pkg::date_t     date_s2
);

	logic signed [dsdn_pkg::DigitW-1:0] dg [8];
	logic signed [dsdn_pkg::YearW-1:0]  year;
	logic signed [dsdn_pkg::FieldW-1:0] month;
	logic signed [dsdn_pkg::FieldW-1:0] day;
	logic                               ok;
	logic [dsdn_pkg::YearW-1:0]         prev_full;
	dsdn_pkg::date_t                    date_d;

	function automatic logic signed [dsdn_pkg::DigitW-1:0] digit(
		input logic [dsdn_pkg::CharW-1:0] b);
		return $signed({1'b0, b}) - 9'sd48;
	endfunction

	function automatic logic signed [dsdn_pkg::YearW-1:0] wy(
		input logic signed [dsdn_pkg::DigitW-1:0] d);
		return {{(dsdn_pkg::YearW-dsdn_pkg::DigitW){d[dsdn_pkg::DigitW-1]}}, d};
	endfunction

	function automatic logic signed [dsdn_pkg::FieldW-1:0] wf(
		input logic signed [dsdn_pkg::DigitW-1:0] d);
		return {{(dsdn_pkg::FieldW-dsdn_pkg::DigitW){d[dsdn_pkg::DigitW-1]}}, d};
	endfunction

	always_comb begin
		dg[0] = digit(req_s1.year_char_thousands);
		dg[1] = digit(req_s1.year_char_hundreds);
		dg[2] = digit(req_s1.year_char_tens);
		dg[3] = digit(req_s1.year_char_units);
		dg[4] = digit(req_s1.month_char_tens);
		dg[5] = digit(req_s1.month_char_units);
		dg[6] = digit(req_s1.day_char_tens);
		dg[7] = digit(req_s1.day_char_units);

		year  = wy(dg[0]) * 20'sd1000 + wy(dg[1]) * 20'sd100
		      + wy(dg[2]) * 20'sd10 + wy(dg[3]);
		month = wf(dg[4]) * 14'sd10 + wf(dg[5]);
		day   = wf(dg[6]) * 14'sd10 + wf(dg[7]);

		ok = (day >= 14'sd1) && (day <= 14'sd31) &&
		     (month >= 14'sd1) && (month <= 14'sd12) &&
		     (year >= 20'sd1900) && (year <= 20'sd9999);

		prev_full    = $unsigned(year - 20'sd1);
		date_d.ok    = ok;
		date_d.prev  = prev_full[dsdn_pkg::PrevW-1:0];
		date_d.month = month[dsdn_pkg::MonthW-1:0];
		date_d.day   = day[dsdn_pkg::DayW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		date_s2 <= date_d;
	end

endmodule

>>> hdl/dsdn_count.sv
// ----------------------------------------------------------------------------
// dsdn_count
// Forms the day count from a checked date: century by reciprocal multiply
// in one stage, then leap test and the final sum into the result register.
// ----------------------------------------------------------------------------
module dsdn_count (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld_s2,
	input  dsdn_pkg::date_t    date_s2,
	output logic               done,
	output dsdn_pkg::result_t  result
);

	logic [dsdn_pkg::ProdW-1:0]  prod;
	logic                        vld_s3;
	dsdn_pkg::date_t             date_s3;
	logic [dsdn_pkg::CentW-1:0]  cent_s3;
	logic [dsdn_pkg::PrevW-1:0]  rem_full;
	logic [dsdn_pkg::CentW-1:0]  rem;
	logic                        leap;
	logic [dsdn_pkg::CountW-1:0] count;
	logic [dsdn_pkg::MonthW-1:0] midx;
	logic                        done_q;
	dsdn_pkg::result_t           result_q;
	dsdn_pkg::result_t           result_d;

	assign prod = dsdn_pkg::ProdW'(date_s2.prev) * dsdn_pkg::ProdW'(dsdn_pkg::Recip100);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		date_s3 <= date_s2;
		cent_s3 <= prod[dsdn_pkg::RecipSh +: dsdn_pkg::CentW];
	end

	always_comb begin
		rem_full = date_s3.prev - dsdn_pkg::PrevW'(cent_s3) * 14'd100;
		rem      = rem_full[dsdn_pkg::CentW-1:0];
		// year is prev + 1: leap adds a day after February when prev is 3 mod 4,
		// except at a century year that is not a multiple of 400
		leap = (date_s3.month > dsdn_pkg::MonthFeb) && (date_s3.prev[1:0] == 2'b11) &&
		       ((rem != dsdn_pkg::CentLast) || (cent_s3[1:0] == 2'b11));
		midx = date_s3.month - 4'd1;

		count = dsdn_pkg::CountW'(date_s3.prev) * 22'd365
		      + dsdn_pkg::CountW'(date_s3.prev[dsdn_pkg::PrevW-1:2])
		      - dsdn_pkg::CountW'(cent_s3)
		      + dsdn_pkg::CountW'(cent_s3[dsdn_pkg::CentW-1:2])
		      + dsdn_pkg::CountW'(dsdn_pkg::days_before(midx))
		      + dsdn_pkg::CountW'(date_s3.day)
		      + dsdn_pkg::CountW'(leap);

		result_d.date_valid = date_s3.ok;
		result_d.day_number = date_s3.ok ? count : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

>>> hdl/date_string_to_day_number_core.sv
// ----------------------------------------------------------------------------
// date_string_to_day_number_core
// Throughput: one request per cycle; busy stays low, four-stage pipeline.
// Results are strobed on done for one cycle; the receiver cannot stall.
// Reset clears the stage valid bits only; no results follow reset.
// ----------------------------------------------------------------------------
module date_string_to_day_number_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  dsdn_pkg::request_t request,
	output logic               done,
	output dsdn_pkg::result_t  result
);

	logic               vld_s1;
	dsdn_pkg::request_t req_s1;
	logic               vld_s2;
	dsdn_pkg::date_t    date_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		req_s1 <= request;
	end

	dsdn_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_s1  (vld_s1),
		.req_s1  (req_s1),
		.vld_s2  (vld_s2),
		.date_s2 (date_s2)
	);

	dsdn_count u_count (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_s2  (vld_s2),
		.date_s2 (date_s2),
		.done    (done),
		.result  (result)
	);

endmodule
